@@ hw/rtl/scs_pkg.sv @@
// ----------------------------------------------------------------------------
// scs_pkg: shared types and constants of the shadow call stack
// Sizes, event and status codes, entry layout and the command record.
// ----------------------------------------------------------------------------
package scs_pkg;

  localparam int STACK_DEPTH = 512;
  localparam int THREADS     = 4;
  localparam int ADDR_BITS   = 48;

  localparam int TID_W   = 2;
  localparam int ADDR_W  = 48;
  localparam int TW      = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int IW      = $clog2(STACK_DEPTH);
  localparam int SW      = $clog2(STACK_DEPTH + 1);
  localparam int RW      = SW + 1;
  localparam int ENTRY_W = ADDR_W + 2;
  localparam int MEM_DEPTH = THREADS * STACK_DEPTH;
  localparam int DEPTH_W = 10;

  localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'((65'd1 << ADDR_BITS) - 65'd1);

  localparam logic [1:0] KIND_CALL = 2'd1;
  localparam logic [1:0] KIND_RET  = 2'd2;
  localparam logic [1:0] KIND_MARK = 2'd3;

  typedef enum logic [2:0] {
    OP_CALL    = 3'd0,
    OP_RET     = 3'd1,
    OP_XBEGIN  = 3'd2,
    OP_XCOMMIT = 3'd3,
    OP_XABORT  = 3'd4,
    OP_START   = 3'd5,
    OP_FORK    = 3'd6,
    OP_BAD     = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_IGN    = 3'd1,
    ST_ABORT  = 3'd2,
    ST_FORKTX = 3'd3,
    ST_OVF    = 3'd4,
    ST_NOTST  = 3'd5,
    ST_BADRPL = 3'd6
  } st_e;

  typedef struct packed {
    op_e               op;
    logic [TID_W-1:0]  tid;
    logic [TID_W-1:0]  par;
    logic [ADDR_W-1:0] addr;
    logic              sig;
  } cmd_t;

endpackage

@@ hw/rtl/shadow_call_stack_with_transactions_unit.sv @@
// Call, xbegin, xabort, start and other one-step events go from queue head
// to result register without a memory walk; ret unwinding walks one entry
// at a time, commit replay handles each logged entry in turn and fork copies
// entry by entry, all through the single read port of the entry memory.
// The engine takes no new event until the result of the last one is loaded.
// Reset clears all per-thread state at once; the entry memory is not cleared.
// ----------------------------------------------------------------------------
// shadow_call_stack_with_transactions_unit: per-thread shadow call stack
// Intake, a two-entry command queue and the stack engine.
// ----------------------------------------------------------------------------
module shadow_call_stack_with_transactions_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [1:0]  thread_id_i,
  input  logic [1:0]  parent_thread_i,
  input  logic [47:0] target_address_i,
  input  logic        is_sigreturn_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [9:0]  stack_depth_o,
  output logic        in_transaction_o
);

  scs_pkg::cmd_t f_cmd, q_cmd;
  logic push, full, pop, q_valid;

  scs_front u_front (
    .in_valid_i, .in_ready_o, .opcode_i, .thread_id_i, .parent_thread_i,
    .target_address_i, .is_sigreturn_i,
    .push_o(push), .full_i(full), .cmd_o(f_cmd)
  );

  scs_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .cmd_i(f_cmd), .full_o(full),
    .pop_i(pop), .valid_o(q_valid), .cmd_o(q_cmd)
  );

  scs_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_cmd_i(q_cmd), .q_pop_o(pop),
    .out_valid_o, .out_ready_i, .status_o, .stack_depth_o, .in_transaction_o
  );

endmodule

@@ hw/rtl/scs_front.sv @@
// ----------------------------------------------------------------------------
// scs_front: event intake
// Decodes the opcode and packs one event into a command record.
// ----------------------------------------------------------------------------
module scs_front (
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [2:0]                opcode_i,
  input  logic [1:0]                thread_id_i,
  input  logic [1:0]                parent_thread_i,
  input  logic [47:0]               target_address_i,
  input  logic                      is_sigreturn_i,
  output logic                      push_o,
  input  logic                      full_i,
  output scs_pkg::cmd_t             cmd_o
);

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    cmd_o.op   = scs_pkg::op_e'(opcode_i);
    cmd_o.tid  = thread_id_i;
    cmd_o.par  = parent_thread_i;
    // keep only the compared address bits
    cmd_o.addr = target_address_i & scs_pkg::ADDR_MASK;
    // sigreturn only matters for a ret
    cmd_o.sig  = is_sigreturn_i && (scs_pkg::op_e'(opcode_i) == scs_pkg::OP_RET);
  end

endmodule

@@ hw/rtl/scs_queue.sv @@
// ----------------------------------------------------------------------------
// scs_queue: two-entry command queue
// Decouples event intake from the stack engine.
// ----------------------------------------------------------------------------
module scs_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  scs_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output scs_pkg::cmd_t cmd_o
);

  scs_pkg::cmd_t slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q[1];
  assign valid_o = cnt_q != 2'd0;
  assign cmd_o   = slot_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wp_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i)  rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

@@ hw/rtl/scs_back.sv @@
// ----------------------------------------------------------------------------
// scs_back: stack engine
// Holds the per-thread state and entry memory, executes one command at a
// time and registers its result.
// ----------------------------------------------------------------------------
module scs_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  scs_pkg::cmd_t q_cmd_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [2:0]    status_o,
  output logic [9:0]    stack_depth_o,
  output logic          in_transaction_o
);

  localparam int SW = scs_pkg::SW;
  localparam int RW = scs_pkg::RW;
  localparam int TW = scs_pkg::TW;
  localparam int IW = scs_pkg::IW;
  localparam int MW = $clog2(scs_pkg::MEM_DEPTH);
  localparam logic [SW-1:0] DMAX = SW'(scs_pkg::STACK_DEPTH);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_UNW   = 7'b0000010,
    S_RPL   = 7'b0000100,
    S_RNEXT = 7'b0001000,
    S_CRD   = 7'b0010000,
    S_CWR   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [SW-1:0] sp_q [scs_pkg::THREADS];
  logic [SW-1:0] sp_d [scs_pkg::THREADS];
  logic [SW-1:0] mk_q [scs_pkg::THREADS];
  logic [SW-1:0] mk_d [scs_pkg::THREADS];
  logic [scs_pkg::THREADS-1:0] to_q, to_d, ts_q, ts_d;

  scs_pkg::cmd_t cmd_q, cmd_d, c;
  scs_pkg::st_e  st_q, st_d;
  logic [SW-1:0] i_q, i_d, d_q, d_d;
  logic [RW-1:0] r_q, r_d;
  logic [scs_pkg::ADDR_W-1:0] ua_q, ua_d;
  logic rpl_q, rpl_d;

  logic [scs_pkg::ENTRY_W-1:0] mem [scs_pkg::MEM_DEPTH];
  logic [scs_pkg::ENTRY_W-1:0] rdata_q, wdata;
  logic [MW-1:0] raddr, waddr;
  logic          we;

  logic ov_q, load;
  scs_pkg::st_e  ost_q;
  logic [9:0]    odep_q;
  logic          otx_q;

  logic [TW-1:0] t, p;
  logic tv, pv;
  logic [SW-1:0] sp_t, m, dd;
  logic [RW-1:0] rr;
  logic [1:0]    ekind;
  logic [scs_pkg::ADDR_W-1:0] eaddr;

  function automatic logic [MW-1:0] maddr(logic [TW-1:0] th, logic [SW-1:0] idx);
    maddr = MW'({th, idx[IW-1:0]});
  endfunction

  assign c     = (state_q == S_IDLE) ? q_cmd_i : cmd_q;
  assign t     = c.tid[TW-1:0];
  assign p     = c.par[TW-1:0];
  assign tv    = int'(c.tid) < scs_pkg::THREADS;
  assign pv    = int'(c.par) < scs_pkg::THREADS;
  assign sp_t  = sp_q[t];
  assign ekind = rdata_q[scs_pkg::ENTRY_W-1 -: 2];
  assign eaddr = rdata_q[scs_pkg::ADDR_W-1:0];
  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;

  always_comb begin
    state_d = state_q;
    sp_d = sp_q; mk_d = mk_q; to_d = to_q; ts_d = ts_q;
    cmd_d = cmd_q; st_d = st_q;
    i_d = i_q; d_d = d_q; r_d = r_q; ua_d = ua_q; rpl_d = rpl_q;
    we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
    m = '0; dd = '0; rr = '0;
    load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          cmd_d   = q_cmd_i;
          state_d = S_DONE;
          st_d    = scs_pkg::ST_OK;
          case (c.op)
            scs_pkg::OP_START: begin
              if (!tv) st_d = scs_pkg::ST_NOTST;
              else if (ts_q[t]) st_d = scs_pkg::ST_IGN;
              else begin
                ts_d[t] = 1'b1; sp_d[t] = '0; mk_d[t] = '0; to_d[t] = 1'b0;
              end
            end
            scs_pkg::OP_FORK: begin
              dd = (sp_q[p] > DMAX) ? DMAX : sp_q[p];
              if (!tv || !pv || !ts_q[p]) st_d = scs_pkg::ST_NOTST;
              else if (to_q[p]) st_d = scs_pkg::ST_FORKTX;
              else if (t != p && dd != '0) begin
                d_d = dd; i_d = '0; state_d = S_CRD;
              end else begin
                sp_d[t] = dd; mk_d[t] = '0; to_d[t] = 1'b0; ts_d[t] = 1'b1;
              end
            end
            scs_pkg::OP_BAD: st_d = scs_pkg::ST_IGN;
            default: begin
              if (!tv || !ts_q[t]) st_d = scs_pkg::ST_NOTST;
              else begin
                case (c.op)
                  scs_pkg::OP_CALL: begin
                    if (sp_t >= DMAX) st_d = scs_pkg::ST_OVF;
                    else begin
                      we = 1'b1; waddr = maddr(t, sp_t);
                      wdata = {scs_pkg::KIND_CALL, c.addr};
                      sp_d[t] = sp_t + SW'(1);
                    end
                  end
                  scs_pkg::OP_RET: begin
                    if (c.sig) st_d = scs_pkg::ST_IGN;
                    else if (sp_t == '0) begin
                      we = 1'b1; waddr = maddr(t, '0);
                      wdata = {scs_pkg::KIND_RET, c.addr};
                      sp_d[t] = SW'(1);
                    end else begin
                      ua_d = c.addr; rpl_d = 1'b0; i_d = sp_t;
                      raddr = maddr(t, sp_t - SW'(1));
                      state_d = S_UNW;
                    end
                  end
                  scs_pkg::OP_XBEGIN: begin
                    if (to_q[t]) st_d = scs_pkg::ST_IGN;
                    else if (sp_t >= DMAX) st_d = scs_pkg::ST_OVF;
                    else begin
                      we = 1'b1; waddr = maddr(t, sp_t);
                      wdata = {scs_pkg::KIND_MARK, {scs_pkg::ADDR_W{1'b0}}};
                      mk_d[t] = sp_t; to_d[t] = 1'b1;
                      sp_d[t] = sp_t + SW'(1);
                    end
                  end
                  scs_pkg::OP_XCOMMIT: begin
                    m  = (mk_q[t] < sp_t) ? mk_q[t] : sp_t;
                    rr = {1'b0, m} + RW'(1);
                    if (!to_q[t]) st_d = scs_pkg::ST_IGN;
                    else begin
                      d_d = sp_t; sp_d[t] = m;
                      if (rr < {1'b0, sp_t} && rr < {1'b0, DMAX}) begin
                        r_d = rr; raddr = maddr(t, rr[SW-1:0]);
                        state_d = S_RPL;
                      end else to_d[t] = 1'b0;
                    end
                  end
                  default: begin
                    if (!to_q[t]) st_d = scs_pkg::ST_ABORT;
                    else begin
                      if (mk_q[t] < sp_t) sp_d[t] = mk_q[t];
                      to_d[t] = 1'b0;
                    end
                  end
                endcase
              end
            end
          endcase
        end
      end
      S_UNW: begin
        if (ekind != scs_pkg::KIND_CALL || eaddr == ua_q || i_q == SW'(1)) begin
          state_d = rpl_q ? S_RNEXT : S_DONE;
          st_d    = scs_pkg::ST_OK;
          if (ekind != scs_pkg::KIND_CALL) begin
            if (i_q >= DMAX) begin
              st_d = scs_pkg::ST_OVF; state_d = S_DONE;
              if (rpl_q) to_d[t] = 1'b0;
            end else begin
              we = 1'b1; waddr = maddr(t, i_q);
              wdata = {scs_pkg::KIND_RET, ua_q};
              sp_d[t] = i_q + SW'(1);
            end
          end else if (eaddr == ua_q) begin
            sp_d[t] = i_q - SW'(1);
          end else begin
            // reached the bottom: leave a ret entry there
            we = 1'b1; waddr = maddr(t, '0);
            wdata = {scs_pkg::KIND_RET, ua_q};
            sp_d[t] = SW'(1);
          end
        end else begin
          i_d   = i_q - SW'(1);
          raddr = maddr(t, i_q - SW'(2));
        end
      end
      S_RPL: begin
        if (ekind == scs_pkg::KIND_CALL) begin
          if (sp_t >= DMAX) begin
            st_d = scs_pkg::ST_OVF; to_d[t] = 1'b0; state_d = S_DONE;
          end else begin
            we = 1'b1; waddr = maddr(t, sp_t);
            wdata = {scs_pkg::KIND_CALL, eaddr};
            sp_d[t] = sp_t + SW'(1);
            state_d = S_RNEXT;
          end
        end else if (ekind == scs_pkg::KIND_RET) begin
          ua_d = eaddr; rpl_d = 1'b1;
          if (sp_t == '0) begin
            we = 1'b1; waddr = maddr(t, '0);
            wdata = {scs_pkg::KIND_RET, eaddr};
            sp_d[t] = SW'(1);
            state_d = S_RNEXT;
          end else begin
            i_d = sp_t; raddr = maddr(t, sp_t - SW'(1));
            state_d = S_UNW;
          end
        end else begin
          st_d = scs_pkg::ST_BADRPL; to_d[t] = 1'b0; state_d = S_DONE;
        end
      end
      S_RNEXT: begin
        rr = r_q + RW'(1);
        if (rr < {1'b0, d_q} && rr < {1'b0, DMAX}) begin
          r_d = rr; raddr = maddr(t, rr[SW-1:0]);
          state_d = S_RPL;
        end else begin
          to_d[t] = 1'b0; st_d = scs_pkg::ST_OK; state_d = S_DONE;
        end
      end
      S_CRD: begin
        raddr   = maddr(p, i_q);
        state_d = S_CWR;
      end
      S_CWR: begin
        we = 1'b1; waddr = maddr(t, i_q); wdata = rdata_q;
        i_d = i_q + SW'(1);
        if (i_q + SW'(1) < d_q) state_d = S_CRD;
        else begin
          sp_d[t] = d_q; mk_d[t] = '0; to_d[t] = 1'b0; ts_d[t] = 1'b1;
          st_d = scs_pkg::ST_OK; state_d = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!ov_q || out_ready_i) begin
          load = 1'b1; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; st_q <= st_d;
    i_q <= i_d; d_q <= d_d; r_q <= r_d; ua_q <= ua_d;
    if (load) begin
      ost_q  <= st_q;
      odep_q <= tv ? 10'(sp_q[t]) : 10'd0;
      otx_q  <= tv ? to_q[t] : 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rpl_q   <= 1'b0;
      ov_q    <= 1'b0;
      to_q    <= '0;
      ts_q    <= '0;
      for (int k = 0; k < scs_pkg::THREADS; k++) begin
        sp_q[k] <= '0;
        mk_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      rpl_q   <= rpl_d;
      to_q    <= to_d;
      ts_q    <= ts_d;
      sp_q    <= sp_d;
      mk_q    <= mk_d;
      if (load) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  assign out_valid_o      = ov_q;
  assign status_o         = ost_q;
  assign stack_depth_o    = odep_q;
  assign in_transaction_o = otx_q;

endmodule

@@ hw/rtl/scs_checker.sv @@
// ----------------------------------------------------------------------------
// scs_checker: port-level checks of the shadow call stack
// Result handshake and status consistency.
// ----------------------------------------------------------------------------
module scs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] status_o,
  input logic [9:0] stack_depth_o,
  input logic       in_transaction_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(stack_depth_o))
    else $error("result changed while stalled");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= scs_pkg::ST_BADRPL
      && stack_depth_o <= 10'(scs_pkg::STACK_DEPTH))
    else $error("status or depth out of range");

  a_abort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == scs_pkg::ST_ABORT |-> !in_transaction_o)
    else $error("abort outside transaction with open transaction");

  a_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == scs_pkg::ST_OVF |->
      stack_depth_o == 10'(scs_pkg::STACK_DEPTH))
    else $error("overflow on a stack that is not full");

endmodule

bind shadow_call_stack_with_transactions_unit scs_checker u_scs_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .status_o, .stack_depth_o,
  .in_transaction_o
);

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the per-thread shadow call stack
// Drives call, ret, transaction, start and fork events through the valid and
// ready intake, mirrors every stack in a behavioral model and compares each
// result with the oldest prediction, under varying sender and receiver idling.
// ----------------------------------------------------------------------------
module tb;
  import scs_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  opcode_i = '0;
  logic [1:0]  thread_id_i = '0;
  logic [1:0]  parent_thread_i = '0;
  logic [47:0] target_address_i = '0;
  logic        is_sigreturn_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b1;
  logic [2:0]  status_o;
  logic [9:0]  stack_depth_o;
  logic        in_transaction_o;

  shadow_call_stack_with_transactions_unit u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .opcode_i, .thread_id_i,
    .parent_thread_i, .target_address_i, .is_sigreturn_i, .out_valid_o,
    .out_ready_i, .status_o, .stack_depth_o, .in_transaction_o
  );

  typedef struct {
    st_e        st;
    logic [9:0] depth;
    logic       txn;
  } stack_res_t;

  typedef struct {
    op_e         op;
    logic [1:0]  tid;
    logic [1:0]  par;
    logic [47:0] addr;
    logic        sig;
    bit          typed;
    st_e         st;
    logic [9:0]  depth;
    logic        txn;
  } event_row_t;

  // Mirror of the stacks
  logic [ENTRY_W-1:0] shadow_mem [THREADS][STACK_DEPTH];
  int unsigned        shadow_sp [THREADS];
  int unsigned        shadow_mark [THREADS];
  bit                 shadow_txn [THREADS];
  bit                 shadow_started [THREADS];

  stack_res_t pending_res[$];
  int         mismatches = 0;
  int         idle_mode = 0;  // 0 none, 1 sender, 2 receiver, 3 both

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic st_e push_entry(int t, logic [1:0] kind, logic [47:0] a);
    if (shadow_sp[t] >= STACK_DEPTH) return ST_OVF;
    shadow_mem[t][shadow_sp[t]] = {kind, a};
    shadow_sp[t]++;
    return ST_OK;
  endfunction

  function automatic st_e unwind_to_call(int t, logic [47:0] a);
    int unsigned i;
    i = shadow_sp[t];
    while (1) begin
      if (i == 0 || shadow_mem[t][i-1][49:48] != KIND_CALL) begin
        if (i >= STACK_DEPTH) return ST_OVF;
        shadow_mem[t][i] = {KIND_RET, a};
        shadow_sp[t] = i + 1;
        return ST_OK;
      end
      if (shadow_mem[t][i-1][47:0] == a) begin
        shadow_sp[t] = i - 1;
        return ST_OK;
      end
      i--;
    end
  endfunction

  function automatic st_e replay_commit(int t);
    int unsigned m, d, r;
    logic [ENTRY_W-1:0] e;
    st_e st;
    m = shadow_mark[t];
    d = shadow_sp[t];
    st = ST_OK;
    if (m > d) m = d;
    shadow_sp[t] = m;
    for (r = m + 1; r < d && r < STACK_DEPTH; r++) begin
      e = shadow_mem[t][r];
      if (e[49:48] == KIND_CALL) st = push_entry(t, KIND_CALL, e[47:0]);
      else if (e[49:48] == KIND_RET) st = unwind_to_call(t, e[47:0]);
      else st = ST_BADRPL;
      if (st != ST_OK) break;
    end
    shadow_txn[t] = 0;
    return st;
  endfunction

  function automatic stack_res_t apply_event(op_e op, int t, int p, logic [47:0] a,
                                             logic sig);
    stack_res_t r;
    int unsigned d;
    st_e st;
    st = ST_OK;
    if (op == OP_BAD) begin
      st = ST_IGN;
    end else if (op == OP_START) begin
      if (shadow_started[t]) st = ST_IGN;
      else begin
        shadow_started[t] = 1;
        shadow_sp[t] = 0;
        shadow_mark[t] = 0;
        shadow_txn[t] = 0;
      end
    end else if (op == OP_FORK) begin
      if (!shadow_started[p]) st = ST_NOTST;
      else if (shadow_txn[p]) st = ST_FORKTX;
      else begin
        d = shadow_sp[p];
        if (t != p)
          for (int i = 0; i < d; i++) shadow_mem[t][i] = shadow_mem[p][i];
        shadow_sp[t] = d;
        shadow_mark[t] = 0;
        shadow_txn[t] = 0;
        shadow_started[t] = 1;
      end
    end else if (!shadow_started[t]) begin
      st = ST_NOTST;
    end else if (op == OP_CALL) begin
      st = push_entry(t, KIND_CALL, a);
    end else if (op == OP_RET) begin
      st = sig ? ST_IGN : unwind_to_call(t, a);
    end else if (op == OP_XBEGIN) begin
      if (shadow_txn[t]) st = ST_IGN;
      else begin
        d = shadow_sp[t];
        st = push_entry(t, KIND_MARK, '0);
        if (st == ST_OK) begin
          shadow_mark[t] = d;
          shadow_txn[t] = 1;
        end
      end
    end else if (op == OP_XCOMMIT) begin
      st = shadow_txn[t] ? replay_commit(t) : ST_IGN;
    end else begin
      if (!shadow_txn[t]) st = ST_ABORT;
      else begin
        if (shadow_mark[t] < shadow_sp[t]) shadow_sp[t] = shadow_mark[t];
        shadow_txn[t] = 0;
      end
    end
    r.st = st;
    r.depth = shadow_sp[t][9:0];
    r.txn = shadow_txn[t];
    return r;
  endfunction

  // One event: optional gap, present, hold until transfer, then predict.
  task automatic send_event(event_row_t ev);
    stack_res_t r;
    if ((idle_mode == 1 && $urandom_range(0, 99) < 61) ||
        (idle_mode == 3 && $urandom_range(0, 99) < 7)) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    opcode_i         <= ev.op;
    thread_id_i      <= ev.tid;
    parent_thread_i  <= ev.par;
    target_address_i <= ev.addr;
    is_sigreturn_i   <= ev.sig;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    r = apply_event(ev.op, ev.tid, ev.par, ev.addr, ev.sig);
    if (ev.typed) begin
      r.st = ev.st;
      r.depth = ev.depth;
      r.txn = ev.txn;
    end
    pending_res.push_back(r);
  endtask

  function automatic logic [47:0] pick_addr();
    if ($urandom_range(0, 9) < 7) return 48'h4000 + 48'($urandom_range(0, 7) * 4);
    return {$urandom(), $urandom()} & 48'hFFFF_FFFF_FFFF;
  endfunction

  function automatic event_row_t rand_event();
    event_row_t ev;
    int w;
    w = $urandom_range(0, 99);
    if (w < 35) ev.op = OP_CALL;
    else if (w < 60) ev.op = OP_RET;
    else if (w < 70) ev.op = OP_XBEGIN;
    else if (w < 78) ev.op = OP_XCOMMIT;
    else if (w < 85) ev.op = OP_XABORT;
    else if (w < 91) ev.op = OP_START;
    else if (w < 98) ev.op = OP_FORK;
    else ev.op = OP_BAD;
    ev.tid = $urandom_range(0, 3);
    ev.par = $urandom_range(0, 3);
    ev.addr = pick_addr();
    ev.sig = ($urandom_range(0, 9) == 0);
    ev.typed = 0;
    ev.st = ST_OK;
    ev.depth = '0;
    ev.txn = 0;
    return ev;
  endfunction

  function automatic event_row_t mk(op_e op, logic [1:0] t, logic [47:0] a);
    event_row_t ev;
    ev = '{op, t, 2'd0, a, 1'b0, 0, ST_OK, 10'd0, 1'b0};
    return ev;
  endfunction

  // Result check and receiver stalls
  always @(posedge clk_i) begin
    stack_res_t r;
    if (out_valid_o && out_ready_i) begin
      if (pending_res.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: status %0d", status_o);
      end else begin
        r = pending_res.pop_front();
        if (status_o !== r.st || stack_depth_o !== r.depth ||
            in_transaction_o !== r.txn) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st %0d depth %0d txn %0d, got st %0d depth %0d txn %0d",
                     r.st, r.depth, r.txn, status_o, stack_depth_o, in_transaction_o);
        end
      end
    end
    if (idle_mode == 2) out_ready_i <= ($urandom_range(0, 99) >= 61);
    else if (idle_mode == 3) out_ready_i <= ($urandom_range(0, 99) >= 7);
    else out_ready_i <= 1'b1;
  end

  initial begin
    #50ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    event_row_t rows [22];
    event_row_t ev;
    for (int t = 0; t < THREADS; t++) begin
      shadow_sp[t] = 0;
      shadow_mark[t] = 0;
      shadow_txn[t] = 0;
      shadow_started[t] = 0;
      for (int i = 0; i < STACK_DEPTH; i++) shadow_mem[t][i] = '0;
    end
    rows = '{
      '{OP_CALL,    2'd0, 2'd0, 48'h1,              1'b0, 1, ST_NOTST,  10'd0, 1'b0},
      '{OP_START,   2'd0, 2'd0, 48'h0,              1'b0, 1, ST_OK,     10'd0, 1'b0},
      '{OP_START,   2'd0, 2'd0, 48'h0,              1'b0, 1, ST_IGN,    10'd0, 1'b0},
      '{OP_CALL,    2'd0, 2'd0, 48'hFFFF_FFFF_FFFF, 1'b0, 1, ST_OK,     10'd1, 1'b0},
      '{OP_CALL,    2'd0, 2'd0, 48'h0,              1'b0, 1, ST_OK,     10'd2, 1'b0},
      '{OP_RET,     2'd0, 2'd0, 48'h0,              1'b1, 1, ST_IGN,    10'd2, 1'b0},
      '{OP_RET,     2'd0, 2'd0, 48'hFFFF_FFFF_FFFF, 1'b0, 1, ST_OK,     10'd0, 1'b0},
      '{OP_RET,     2'd0, 2'd0, 48'h5,              1'b0, 1, ST_OK,     10'd1, 1'b0},
      '{OP_XABORT,  2'd0, 2'd0, 48'h0,              1'b0, 1, ST_ABORT,  10'd1, 1'b0},
      '{OP_XCOMMIT, 2'd0, 2'd0, 48'h0,              1'b0, 1, ST_IGN,    10'd1, 1'b0},
      '{OP_XBEGIN,  2'd0, 2'd0, 48'h0,              1'b0, 1, ST_OK,     10'd2, 1'b1},
      '{OP_XBEGIN,  2'd0, 2'd0, 48'h0,              1'b0, 1, ST_IGN,    10'd2, 1'b1},
      '{OP_CALL,    2'd0, 2'd0, 48'h10,             1'b0, 0, ST_OK,     10'd0, 1'b0},
      '{OP_RET,     2'd0, 2'd0, 48'h99,             1'b0, 0, ST_OK,     10'd0, 1'b0},
      '{OP_FORK,    2'd1, 2'd0, 48'h0,              1'b0, 1, ST_FORKTX, 10'd0, 1'b0},
      '{OP_XCOMMIT, 2'd0, 2'd0, 48'h0,              1'b0, 0, ST_OK,     10'd0, 1'b0},
      '{OP_FORK,    2'd1, 2'd0, 48'h0,              1'b0, 0, ST_OK,     10'd0, 1'b0},
      '{OP_FORK,    2'd2, 2'd3, 48'h0,              1'b0, 1, ST_NOTST,  10'd0, 1'b0},
      '{OP_XBEGIN,  2'd1, 2'd0, 48'h0,              1'b0, 0, ST_OK,     10'd0, 1'b0},
      '{OP_FORK,    2'd1, 2'd1, 48'h0,              1'b0, 0, ST_OK,     10'd0, 1'b0},
      '{OP_BAD,     2'd3, 2'd0, 48'h0,              1'b0, 1, ST_IGN,    10'd0, 1'b0},
      '{OP_START,   2'd3, 2'd0, 48'h0,              1'b0, 0, ST_OK,     10'd0, 1'b0}
    };
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_event(rows[i]);
    send_event(mk(OP_START, 2'd2, '0));

    for (int n = 0; n < 500; n++) begin
      idle_mode = (n / 100) % 4;
      if (n == 250) begin
        // Drain, then fill thread two to the top for the overflow cases.
        in_valid_i <= 1'b0;
        while (pending_res.size() != 0) @(posedge clk_i);
        send_event(mk(OP_XABORT, 2'd2, '0));
        while (shadow_sp[2] < STACK_DEPTH - 1) send_event(mk(OP_CALL, 2'd2, pick_addr()));
        send_event(mk(OP_XBEGIN, 2'd2, '0));
        send_event(mk(OP_RET, 2'd2, 48'hDEAD));
        send_event(mk(OP_CALL, 2'd2, 48'h1));
        send_event(mk(OP_XCOMMIT, 2'd2, '0));
        send_event(mk(OP_RET, 2'd2, 48'hBEEF_0000_0001));
      end
      ev = rand_event();
      send_event(ev);
    end
    in_valid_i <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && pending_res.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
